[rtl/polygon_halfplane_constraints_defines.svh]
// Assertion macros shared by the polygon half-plane constraint RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef POLYGON_HALFPLANE_CONSTRAINTS_DEFINES_SVH
`define POLYGON_HALFPLANE_CONSTRAINTS_DEFINES_SVH

// check a condition at every edge outside reset
`define PHC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// check a consequence in the cycle after its trigger
`define PHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/phc_pkg.sv]
// Package for the polygon half-plane constraint block: sizes and the edge job type.
// No dependencies.
package phc_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic signed [15:0] xa;
        logic signed [15:0] ya;
        logic signed [15:0] xb;
        logic signed [15:0] yb;
        logic signed [15:0] xc;
        logic signed [15:0] yc;
        logic        [7:0]  idx;
        logic               last;
    } t_job;

endpackage

[rtl/phc_front.sv]
// Front end: accepts vertices, tracks polygon state, and issues edge jobs.
// Depends on phc_pkg and polygon_halfplane_constraints_defines.svh.
`include "polygon_halfplane_constraints_defines.svh"

module phc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [15:0]  i_vertex_x,
    input  logic signed [15:0]  i_vertex_y,
    input  logic                i_last_vertex,
    output logic                o_job_valid,
    output phc_pkg::t_job       o_job,
    input  logic                i_job_stall
);

    logic signed [15:0] r_first_x, r_first_y, r_second_x, r_second_y;
    logic signed [15:0] r_older_x, r_older_y, r_newer_x, r_newer_y;
    logic signed [15:0] n_first_x, n_first_y, n_second_x, n_second_y;
    logic signed [15:0] n_older_x, n_older_y, n_newer_x, n_newer_y;
    logic [7:0]         r_vcount, n_vcount;
    phc_pkg::t_job      r_jobs [3];
    phc_pkg::t_job      n_jobs [3];
    logic [1:0]         r_cnt, n_cnt;
    logic               push;
    logic               accept;
    logic               last;

    function automatic phc_pkg::t_job make_job(
        input logic signed [15:0] xa, input logic signed [15:0] ya,
        input logic signed [15:0] xb, input logic signed [15:0] yb,
        input logic signed [15:0] xc, input logic signed [15:0] yc,
        input logic [7:0] idx, input logic lst
    );
        phc_pkg::t_job j;
        j.xa   = xa;
        j.ya   = ya;
        j.xb   = xb;
        j.yb   = yb;
        j.xc   = xc;
        j.yc   = yc;
        j.idx  = idx;
        j.last = lst;
        return j;
    endfunction

    assign push        = (r_cnt != 2'd0) && !i_job_stall;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_jobs[0];
    assign o_stall     = (r_cnt > 2'd1) || ((r_cnt == 2'd1) && i_job_stall);
    assign accept      = i_valid && !o_stall;
    assign last        = i_last_vertex ||
                         (({1'b0, r_vcount} + 9'd1) >= 9'(phc_pkg::MAX_VERTICES));

    always_comb begin
        n_first_x  = r_first_x;
        n_first_y  = r_first_y;
        n_second_x = r_second_x;
        n_second_y = r_second_y;
        n_older_x  = r_older_x;
        n_older_y  = r_older_y;
        n_newer_x  = r_newer_x;
        n_newer_y  = r_newer_y;
        n_vcount   = r_vcount;
        n_jobs     = r_jobs;
        n_cnt      = r_cnt;
        if (push) begin
            n_jobs[0] = r_jobs[1];
            n_jobs[1] = r_jobs[2];
            n_cnt     = r_cnt - 2'd1;
        end
        if (accept) begin
            n_vcount = last ? 8'd0 : (r_vcount + 8'd1);
            case (r_vcount)
                8'd0: begin
                    n_first_x = i_vertex_x;
                    n_first_y = i_vertex_y;
                    n_older_x = i_vertex_x;
                    n_older_y = i_vertex_y;
                    n_newer_x = i_vertex_x;
                    n_newer_y = i_vertex_y;
                    n_jobs[0] = make_job(i_vertex_x, i_vertex_y, i_vertex_x, i_vertex_y,
                                         i_vertex_x, i_vertex_y, 8'd0, 1'b1);
                    n_cnt     = last ? 2'd1 : 2'd0;
                end
                8'd1: begin
                    n_second_x = i_vertex_x;
                    n_second_y = i_vertex_y;
                    n_older_x  = r_first_x;
                    n_older_y  = r_first_y;
                    n_newer_x  = i_vertex_x;
                    n_newer_y  = i_vertex_y;
                    n_jobs[0]  = make_job(r_first_x, r_first_y, i_vertex_x, i_vertex_y,
                                          r_first_x, r_first_y, 8'd0, 1'b0);
                    n_jobs[1]  = make_job(i_vertex_x, i_vertex_y, r_first_x, r_first_y,
                                          i_vertex_x, i_vertex_y, 8'd1, 1'b1);
                    n_cnt      = last ? 2'd2 : 2'd0;
                end
                default: begin
                    n_older_x = r_newer_x;
                    n_older_y = r_newer_y;
                    n_newer_x = i_vertex_x;
                    n_newer_y = i_vertex_y;
                    n_jobs[0] = make_job(r_older_x, r_older_y, r_newer_x, r_newer_y,
                                         i_vertex_x, i_vertex_y, r_vcount - 8'd2, 1'b0);
                    n_jobs[1] = make_job(r_newer_x, r_newer_y, i_vertex_x, i_vertex_y,
                                         r_first_x, r_first_y, r_vcount - 8'd1, 1'b0);
                    n_jobs[2] = make_job(i_vertex_x, i_vertex_y, r_first_x, r_first_y,
                                         r_second_x, r_second_y, r_vcount, 1'b1);
                    n_cnt     = last ? 2'd3 : 2'd1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_x  <= n_first_x;
        r_first_y  <= n_first_y;
        r_second_x <= n_second_x;
        r_second_y <= n_second_y;
        r_older_x  <= n_older_x;
        r_older_y  <= n_older_y;
        r_newer_x  <= n_newer_x;
        r_newer_y  <= n_newer_y;
        r_jobs     <= n_jobs;
        if (!i_rst_n) begin
            r_vcount <= 8'd0;
            r_cnt    <= 2'd0;
        end else begin
            r_vcount <= n_vcount;
            r_cnt    <= n_cnt;
        end
    end

    `PHC_ASSERT_ALWAYS(a_cnt_range, r_cnt <= 2'd3, "front job count out of range")
    `PHC_ASSERT_ALWAYS(a_vcount_range, r_vcount < 8'(phc_pkg::MAX_VERTICES), "vertex count past limit")
    `PHC_ASSERT_NEXT(a_last_restarts, accept && last, r_vcount == 8'd0, "polygon did not restart")

endmodule

[rtl/phc_fifo.sv]
// Short job queue between the front end and the row datapath.
// Depends on phc_pkg and polygon_halfplane_constraints_defines.svh.
`include "polygon_halfplane_constraints_defines.svh"

module phc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  phc_pkg::t_job i_data,
    output logic          o_full,
    output logic          o_valid,
    output phc_pkg::t_job o_data,
    input  logic          i_pop
);

    phc_pkg::t_job                r_mem [phc_pkg::FIFO_DEPTH];
    logic [phc_pkg::FIFO_AW-1:0]  r_wr, n_wr, r_rd, n_rd;
    logic [phc_pkg::FIFO_CW-1:0]  r_count, n_count;
    logic                         wr_en, rd_en;

    assign o_full  = (r_count == phc_pkg::FIFO_CW'(phc_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_comb begin
        n_wr    = wr_en ? r_wr + phc_pkg::FIFO_AW'(1) : r_wr;
        n_rd    = rd_en ? r_rd + phc_pkg::FIFO_AW'(1) : r_rd;
        n_count = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + phc_pkg::FIFO_CW'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - phc_pkg::FIFO_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `PHC_ASSERT_ALWAYS(a_count_range, r_count <= phc_pkg::FIFO_CW'(phc_pkg::FIFO_DEPTH), "queue count past depth")
    `PHC_ASSERT_ALWAYS(a_no_underflow, !(i_pop && !o_valid), "pop from empty queue")
    `PHC_ASSERT_ALWAYS(a_ptr_match, (r_wr == r_rd) == (!o_valid || o_full), "pointers disagree")

endmodule

[rtl/phc_back.sv]
// Row datapath: edge normal and offset, inward-side test, sign fix, output register.
// Depends on phc_pkg.
module phc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  phc_pkg::t_job       i_job,
    output logic                o_job_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [16:0]  o_normal_x,
    output logic signed [16:0]  o_normal_y,
    output logic signed [32:0]  o_offset,
    output logic [7:0]          o_row_index,
    output logic                o_last_row
);

    typedef struct packed {
        logic signed [16:0] nx;
        logic signed [16:0] ny;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
        logic signed [15:0] xc;
        logic signed [15:0] yc;
        logic [7:0]         idx;
        logic               last;
    } t_s1;

    typedef struct packed {
        logic signed [16:0] nx;
        logic signed [16:0] ny;
        logic signed [32:0] off;
        logic signed [32:0] e1;
        logic signed [32:0] e2;
        logic [7:0]         idx;
        logic               last;
    } t_s2;

    typedef struct packed {
        logic signed [16:0] nx;
        logic signed [16:0] ny;
        logic signed [32:0] off;
        logic               neg;
        logic [7:0]         idx;
        logic               last;
    } t_s3;

    t_s1                r_s1, n_s1;
    t_s2                r_s2, n_s2;
    t_s3                r_s3, n_s3;
    logic               r_v1, r_v2, r_v3, r_vo;
    logic signed [34:0] eval;
    logic               adv;

    assign adv       = !(r_vo && i_stall);
    assign o_job_pop = adv && i_job_valid;
    assign o_valid   = r_vo;

    always_comb begin
        n_s1.nx   = 17'(i_job.yb) - 17'(i_job.ya);
        n_s1.ny   = 17'(i_job.xa) - 17'(i_job.xb);
        n_s1.p1   = 32'(i_job.ya) * 32'(i_job.xb);
        n_s1.p2   = 32'(i_job.xa) * 32'(i_job.yb);
        n_s1.xc   = i_job.xc;
        n_s1.yc   = i_job.yc;
        n_s1.idx  = i_job.idx;
        n_s1.last = i_job.last;

        n_s2.nx   = r_s1.nx;
        n_s2.ny   = r_s1.ny;
        n_s2.off  = 33'(r_s1.p1) - 33'(r_s1.p2);
        n_s2.e1   = 33'(r_s1.nx) * 33'(r_s1.xc);
        n_s2.e2   = 33'(r_s1.ny) * 33'(r_s1.yc);
        n_s2.idx  = r_s1.idx;
        n_s2.last = r_s1.last;

        eval      = 35'(r_s2.e1) + 35'(r_s2.e2) + 35'(r_s2.off);
        n_s3.nx   = r_s2.nx;
        n_s3.ny   = r_s2.ny;
        n_s3.off  = r_s2.off;
        n_s3.neg  = eval[34];
        n_s3.idx  = r_s2.idx;
        n_s3.last = r_s2.last;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1        <= n_s1;
            r_s2        <= n_s2;
            r_s3        <= n_s3;
            o_normal_x  <= r_s3.neg ? -r_s3.nx : r_s3.nx;
            o_normal_y  <= r_s3.neg ? -r_s3.ny : r_s3.ny;
            o_offset    <= r_s3.neg ? -r_s3.off : r_s3.off;
            o_row_index <= r_s3.idx;
            o_last_row  <= r_s3.last;
        end
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_job_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vo <= r_v3;
        end
    end

endmodule

[rtl/polygon_halfplane_constraints.sv]
// Channel   Dir  Handshake         Payload
// vertex    in   i_valid/o_stall   i_vertex_x, i_vertex_y, i_last_vertex
// row       out  o_valid/i_stall   o_normal_x, o_normal_y, o_offset, o_row_index, o_last_row
// One vertex per cycle unless o_stall is high; a final vertex queues up to three rows in the front end.
// A row's job passes through three stages plus the output register before the row leaves.
// Synchronous active-low reset clears counts and valids; no clearing pass.
// An output stall while o_valid is high freezes the datapath; the four-entry job queue absorbs the front end.
// Top level: phc_front, phc_fifo and phc_back; depends on phc_pkg.
module polygon_halfplane_constraints (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [15:0]  i_vertex_x,
    input  logic signed [15:0]  i_vertex_y,
    input  logic                i_last_vertex,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [16:0]  o_normal_x,
    output logic signed [16:0]  o_normal_y,
    output logic signed [32:0]  o_offset,
    output logic [7:0]          o_row_index,
    output logic                o_last_row
);

    logic          job_push, job_full, job_valid, job_pop;
    phc_pkg::t_job push_job, pop_job;

    phc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_last_vertex (i_last_vertex),
        .o_job_valid   (job_push),
        .o_job         (push_job),
        .i_job_stall   (job_full)
    );

    phc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (push_job),
        .o_full  (job_full),
        .o_valid (job_valid),
        .o_data  (pop_job),
        .i_pop   (job_pop)
    );

    phc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (pop_job),
        .o_job_pop   (job_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_normal_x  (o_normal_x),
        .o_normal_y  (o_normal_y),
        .o_offset    (o_offset),
        .o_row_index (o_row_index),
        .o_last_row  (o_last_row)
    );

endmodule
